@@ design/atbl_pkg.sv @@
// Package for the antenna tuner band link: field widths, band thresholds, shared types.
`default_nettype none
package atbl_pkg;

  localparam int unsigned OscW   = 32;
  localparam int unsigned BandW  = 4;
  localparam int unsigned TicksW = 16;
  localparam int unsigned PhaseW = 8;
  localparam int unsigned NumEdges = 12;

  localparam int unsigned InDataW  = 40;  // 34 field bits rounded up to bytes
  localparam int unsigned OutDataW = 8;   // 7 field bits rounded up to bytes

  // Configuration register indexes
  localparam logic CFG_TUNE_TICKS = 1'b0;
  localparam logic CFG_BAND_TICKS = 1'b1;

  localparam logic [TicksW-1:0] TUNE_TICKS_RST = 16'd1000;
  localparam logic [TicksW-1:0] BAND_TICKS_RST = 16'd10;

  // Band thresholds, highest band first
  localparam logic [OscW-1:0] BAND_EDGE [NumEdges] = '{
    32'h1b80_0000, 32'h0f80_0000, 32'h0d00_0000, 32'h0b00_0000,
    32'h0980_0000, 32'h0800_0000, 32'h0600_0000, 32'h0480_0000,
    32'h0300_0000, 32'h0280_0000, 32'h0180_0000, 32'h00c0_0000
  };

  // One tick as taken from the input beat
  typedef struct packed {
    logic [OscW-1:0] osc_word;
    logic            sense_level;
    logic            tune_pulse;
  } tick_t;

  // Line levels and band after one tick
  typedef struct packed {
    logic             data_level;
    logic             data_enable;
    logic             tune_level;
    logic [BandW-1:0] sent_band;
  } lines_t;

endpackage
`default_nettype wire

@@ design/antenna_tuner_band_link.sv @@
// Top level of the antenna tuner band link: input and result registers around the link engine.
//
// Each input beat is one timer tick and produces exactly one result beat carrying the
// tuner line levels and the band last sent after that tick. A tick is held in the input
// register and then worked combinationally into the result register, so a beat can be taken
// every clock while m_axis_tready does not stall; the result register lets a new tick enter
// while the previous result waits for m_axis_tready. Registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i (0: tune pulse length, 1: band pulse length, both in ticks);
// the user must do so only while no beat is in flight, which the block does not enforce.
`default_nettype none
module antenna_tuner_band_link (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [atbl_pkg::TicksW-1:0]   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] osc_word, [32] sense_level, [33] tune_pulse, [39:34] zero
  input  logic [atbl_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] data_level, [1] data_enable, [2] tune_level, [6:3] sent_band, [7] zero
  output logic [atbl_pkg::OutDataW-1:0] m_axis_tdata
);
  import atbl_pkg::*;

  logic   in_valid_q;
  tick_t  in_q;
  logic   out_valid_q;
  lines_t out_q;
  lines_t lines;
  logic   advance;

  // Move the held tick into the result slot when that slot is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  atbl_link_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (advance),
    .tick_i     (in_q),
    .lines_o    (lines)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.osc_word    <= s_axis_tdata[OscW-1:0];
      in_q.sense_level <= s_axis_tdata[OscW];
      in_q.tune_pulse  <= s_axis_tdata[OscW+1];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= lines;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.sent_band, out_q.tune_level, out_q.data_enable,
                          out_q.data_level};

endmodule
`default_nettype wire

@@ design/atbl_band_class.sv @@
// Band classifier: maps an oscillator word onto band 0..12 by threshold compares.
`default_nettype none
module atbl_band_class (
  input  logic [atbl_pkg::OscW-1:0]  osc_word_i,
  output logic [atbl_pkg::BandW-1:0] band_o
);
  import atbl_pkg::*;

  // Take the highest band whose threshold is exceeded, scanning from the bottom band up
  always_comb begin
    band_o = '0;
    for (int k = NumEdges - 1; k >= 0; k--) begin
      if (osc_word_i > BAND_EDGE[k]) begin
        band_o = BandW'(NumEdges - k);
      end
    end
  end

endmodule
`default_nettype wire

@@ design/atbl_link_core.sv @@
// Per-tick link engine: request latches, tune pulse timer and band send sequencer.
`default_nettype none
module atbl_link_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [atbl_pkg::TicksW-1:0] cfg_data_i,
  input  logic                        step_i,
  input  atbl_pkg::tick_t             tick_i,
  output atbl_pkg::lines_t            lines_o
);
  import atbl_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  localparam logic [PhaseW-1:0] SENSE_MIN = 8'd85;
  localparam logic [PhaseW-1:0] SENSE_MAX = 8'd115;
  localparam logic [PhaseW-1:0] LEAD_LOW  = 8'd20;
  localparam logic [PhaseW-1:0] ONE_HIGH  = 8'd8;
  localparam logic [PhaseW-1:0] ZERO_HIGH = 8'd3;
  localparam logic [PhaseW-1:0] GAP_LOW   = 8'd3;
  localparam logic [PhaseW-1:0] END_LOW   = 8'd10;
  localparam logic [2:0]        NUM_BITS  = 3'd4;

  logic [TicksW-1:0] tune_ticks_q, band_ticks_q;
  logic [OscW-1:0]   last_osc_q, last_osc_d;
  logic [BandW-1:0]  pend_band_q, pend_band_d;
  logic [BandW-1:0]  cur_band_q, cur_band_d;
  logic              band_req_q, band_req_d;
  logic              tune_req_q, tune_req_d;
  logic [TicksW-1:0] pulse_cnt_q, pulse_cnt_d;
  logic [1:0]        phase_q, phase_d;
  logic [PhaseW-1:0] phase_cnt_q, phase_cnt_d;
  logic [BandW-1:0]  shift_q, shift_d;
  logic [2:0]        bits_left_q, bits_left_d;
  logic              data_q, data_d;
  logic              oe_q, oe_d;
  logic              tune_q, tune_d;
  logic [BandW-1:0]  class_band;

  atbl_band_class u_class (
    .osc_word_i (tick_i.osc_word),
    .band_o     (class_band)
  );

  // Work out the state after one tick
  always_comb begin
    last_osc_d  = last_osc_q;
    pend_band_d = pend_band_q;
    cur_band_d  = cur_band_q;
    band_req_d  = band_req_q;
    tune_req_d  = tune_req_q | tick_i.tune_pulse;
    pulse_cnt_d = pulse_cnt_q;
    phase_d     = phase_q;
    phase_cnt_d = phase_cnt_q;
    shift_d     = shift_q;
    bits_left_d = bits_left_q;
    data_d      = data_q;
    oe_d        = oe_q;
    tune_d      = tune_q;

    // classify a new oscillator word
    if (tick_i.osc_word != last_osc_q) begin
      last_osc_d  = tick_i.osc_word;
      pend_band_d = class_band;
      if (class_band != cur_band_q) begin
        band_req_d = 1'b1;
      end
    end

    // count down the tune pulse
    if (pulse_cnt_q != '0) begin
      pulse_cnt_d = pulse_cnt_q - 1'b1;
      if (pulse_cnt_d == '0) begin
        tune_d = 1'b0;
      end
    end

    // step the link sequencer
    case (phase_q)
      PH_IDLE: begin
        if (tick_i.sense_level) begin
          phase_cnt_d = phase_cnt_q + 1'b1;
        end else if (phase_cnt_q inside {[SENSE_MIN:SENSE_MAX]}) begin
          phase_d     = PH_LOW;
          phase_cnt_d = LEAD_LOW;
          cur_band_d  = pend_band_d;
          shift_d     = pend_band_d;
          bits_left_d = NUM_BITS;
          data_d      = 1'b0;
          oe_d        = 1'b1;
        end else begin
          phase_cnt_d = '0;
          if (band_req_d || tune_req_d) begin
            tune_d      = 1'b1;
            pulse_cnt_d = tune_req_d ? tune_ticks_q : band_ticks_q;
            band_req_d  = 1'b0;
            tune_req_d  = 1'b0;
          end
        end
      end
      PH_LOW: begin
        phase_cnt_d = phase_cnt_q - 1'b1;
        if (phase_cnt_d == '0) begin
          if (bits_left_q != '0) begin
            data_d      = 1'b1;
            phase_cnt_d = shift_q[BandW-1] ? ONE_HIGH : ZERO_HIGH;
            shift_d     = {shift_q[BandW-2:0], 1'b0};
            bits_left_d = bits_left_q - 1'b1;
            phase_d     = PH_HIGH;
          end else begin
            data_d  = 1'b0;
            oe_d    = 1'b0;
            phase_d = PH_IDLE;
          end
        end
      end
      PH_HIGH: begin
        phase_cnt_d = phase_cnt_q - 1'b1;
        if (phase_cnt_d == '0) begin
          phase_cnt_d = (bits_left_q != '0) ? GAP_LOW : END_LOW;
          data_d      = 1'b0;
          phase_d     = PH_LOW;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // Result of this tick
  assign lines_o = '{data_level: data_d, data_enable: oe_d, tune_level: tune_d,
                     sent_band: cur_band_d};

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tune_ticks_q <= TUNE_TICKS_RST;
      band_ticks_q <= BAND_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TUNE_TICKS: tune_ticks_q <= cfg_data_i;
        CFG_BAND_TICKS: band_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the state once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_osc_q  <= '0;
      pend_band_q <= '0;
      cur_band_q  <= '0;
      band_req_q  <= 1'b0;
      tune_req_q  <= 1'b0;
      pulse_cnt_q <= '0;
      phase_q     <= PH_IDLE;
      phase_cnt_q <= '0;
      shift_q     <= '0;
      bits_left_q <= '0;
      data_q      <= 1'b0;
      oe_q        <= 1'b0;
      tune_q      <= 1'b0;
    end else if (step_i) begin
      last_osc_q  <= last_osc_d;
      pend_band_q <= pend_band_d;
      cur_band_q  <= cur_band_d;
      band_req_q  <= band_req_d;
      tune_req_q  <= tune_req_d;
      pulse_cnt_q <= pulse_cnt_d;
      phase_q     <= phase_d;
      phase_cnt_q <= phase_cnt_d;
      shift_q     <= shift_d;
      bits_left_q <= bits_left_d;
      data_q      <= data_d;
      oe_q        <= oe_d;
      tune_q      <= tune_d;
    end
  end

endmodule
`default_nettype wire

@@ dv/tb_antenna_tuner_band_link.sv @@
// Testbench for the antenna tuner band link: stream driver, line-level predictor, result checker.
`default_nettype none
module tb_antenna_tuner_band_link;
  import atbl_pkg::*;

  // Link timing in ticks
  localparam int unsigned SenseMin  = 85;
  localparam int unsigned SenseMax  = 115;
  localparam int unsigned LeadLow   = 20;
  localparam int unsigned OneHigh   = 8;
  localparam int unsigned ZeroHigh  = 3;
  localparam int unsigned GapLow    = 3;
  localparam int unsigned TailLow   = 10;
  localparam int unsigned BandBits  = 4;

  localparam int unsigned LongStall   = 60;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;

  typedef enum logic [1:0] {LINK_IDLE, LINK_LOW, LINK_HIGH} link_e;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic                cfg_idx_i     = CFG_TUNE_TICKS;
  logic [TicksW-1:0]   cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [31:0] osc_word, [32] sense_level, [33] tune_pulse, [39:34] zero
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [0] data_level, [1] data_enable, [2] tune_level, [6:3] sent_band, [7] zero
  logic [OutDataW-1:0] m_axis_tdata;

  antenna_tuner_band_link DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Stimulus and expectation stores
  tick_t       ticks_to_send[$];
  lines_t      lines_due[$];
  logic [OscW-1:0] cur_osc = '0;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned stall_requests = 0;
  int unsigned stalls_done = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;

  // Predicted tuner state
  logic [OscW-1:0]   prev_osc;
  logic [BandW-1:0]  queued_band;
  logic [BandW-1:0]  shown_band;
  logic              band_req;
  logic              tune_req;
  logic [TicksW-1:0] pulse_left;
  link_e             link_st;
  logic [PhaseW-1:0] link_cnt;
  logic [BandW-1:0]  band_shift;
  logic [2:0]        bits_to_go;
  logic              line_data;
  logic              line_oe;
  logic              line_tune;
  logic [TicksW-1:0] tune_len;
  logic [TicksW-1:0] band_len;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [BandW-1:0] band_of(input logic [OscW-1:0] w);
    for (int k = 0; k < NumEdges; k++)
      if (w > BAND_EDGE[k]) return BandW'(NumEdges - k);
    return '0;
  endfunction

  function automatic void reset_tuner();
    prev_osc    = '0;
    queued_band = '0;
    shown_band  = '0;
    band_req    = 1'b0;
    tune_req    = 1'b0;
    pulse_left  = '0;
    link_st     = LINK_IDLE;
    link_cnt    = '0;
    band_shift  = '0;
    bits_to_go  = '0;
    line_data   = 1'b0;
    line_oe     = 1'b0;
    line_tune   = 1'b0;
    tune_len    = TUNE_TICKS_RST;
    band_len    = BAND_TICKS_RST;
  endfunction

  // Advance the tuner by one tick and return the line levels after it
  task automatic advance_tuner(input tick_t t, output lines_t r);
    if (t.tune_pulse) tune_req = 1'b1;

    // Reclassify only on a new oscillator word
    if (t.osc_word != prev_osc) begin
      prev_osc    = t.osc_word;
      queued_band = band_of(t.osc_word);
      if (queued_band != shown_band) band_req = 1'b1;
    end

    // Count down a running tune pulse
    if (pulse_left != 0) begin
      pulse_left = pulse_left - 1'b1;
      if (pulse_left == 0) line_tune = 1'b0;
    end

    case (link_st)
      LINK_IDLE: begin
        if (t.sense_level) begin
          link_cnt = link_cnt + 1'b1;
        end else if (link_cnt >= SenseMin && link_cnt <= SenseMax) begin
          link_st    = LINK_LOW;
          link_cnt   = PhaseW'(LeadLow);
          shown_band = queued_band;
          band_shift = queued_band;
          bits_to_go = 3'(BandBits);
          line_data  = 1'b0;
          line_oe    = 1'b1;
        end else begin
          link_cnt = '0;
          if (band_req || tune_req) begin
            line_tune  = 1'b1;
            pulse_left = tune_req ? tune_len : band_len;
            band_req   = 1'b0;
            tune_req   = 1'b0;
          end
        end
      end
      LINK_LOW: begin
        link_cnt = link_cnt - 1'b1;
        if (link_cnt == 0) begin
          if (bits_to_go != 0) begin
            line_data  = 1'b1;
            link_cnt   = band_shift[BandW-1] ? PhaseW'(OneHigh) : PhaseW'(ZeroHigh);
            band_shift = band_shift << 1;
            bits_to_go = bits_to_go - 1'b1;
            link_st    = LINK_HIGH;
          end else begin
            line_data = 1'b0;
            line_oe   = 1'b0;
            link_st   = LINK_IDLE;
          end
        end
      end
      LINK_HIGH: begin
        link_cnt = link_cnt - 1'b1;
        if (link_cnt == 0) begin
          link_cnt  = (bits_to_go != 0) ? PhaseW'(GapLow) : PhaseW'(TailLow);
          line_data = 1'b0;
          link_st   = LINK_LOW;
        end
      end
      default: ;
    endcase

    r.data_level  = line_data;
    r.data_enable = line_oe;
    r.tune_level  = line_tune;
    r.sent_band   = shown_band;
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fail_cnt++;
    end
  endtask

  // Present the next tick once the previous beat is gone
  always @(posedge clk_i or negedge rst_ni) begin : driver
    tick_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (ticks_to_send.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        nxt = ticks_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(InDataW-OscW-2){1'b0}}, nxt.tune_pulse, nxt.sense_level,
                          nxt.osc_word};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Throttle the result side; a requested hold takes priority
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      stalls_done   <= 0;
    end else if (stalls_done != stall_requests) begin
      stalls_done   <= stalls_done + 1;
      stall_left    <= LongStall;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Check result beats, then predict from accepted tick beats
  always @(posedge clk_i) begin : monitor
    lines_t want;
    lines_t next_lines;
    tick_t  seen;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (lines_due.size() == 0) begin
          $error("result beat %h with no tick outstanding", m_axis_tdata);
          fail_cnt++;
        end else begin
          want = lines_due.pop_front();
          check_field("data_level", want.data_level, m_axis_tdata[0]);
          check_field("data_enable", want.data_enable, m_axis_tdata[1]);
          check_field("tune_level", want.tune_level, m_axis_tdata[2]);
          check_field("sent_band", want.sent_band, m_axis_tdata[6:3]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen.osc_word    = s_axis_tdata[OscW-1:0];
        seen.sense_level = s_axis_tdata[OscW];
        seen.tune_pulse  = s_axis_tdata[OscW+1];
        advance_tuner(seen, next_lines);
        lines_due.push_back(next_lines);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void push_tick(input logic [OscW-1:0] osc, input logic sense,
                                    input logic tune);
    tick_t t;
    t.osc_word    = osc;
    t.sense_level = sense;
    t.tune_pulse  = tune;
    ticks_to_send.push_back(t);
    cur_osc = osc;
  endfunction

  // Most often near band edges, sometimes repeat, sometimes any word
  function automatic logic [OscW-1:0] pick_osc();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 25) return cur_osc;
    if (sel < 60) return BAND_EDGE[$urandom_range(NumEdges-1)] - 1 + $urandom_range(2);
    if (sel < 80) return $urandom_range(32'h2000_0000);
    return $urandom;
  endfunction

  // Sense request of the given length, then enough ticks for the band send
  function automatic int unsigned add_handshake(input int unsigned high_len);
    int unsigned n;
    n = 0;
    push_tick(($urandom_range(3) != 0) ? pick_osc() : cur_osc, 1'b0, 1'b0);
    n++;
    for (int unsigned i = 0; i < high_len; i++) begin
      push_tick(cur_osc, 1'b1, $urandom_range(29) == 0);
      n++;
    end
    push_tick(cur_osc, 1'b0, 1'b0);
    n++;
    // Sense is ignored during the send; settle low before the next request
    for (int unsigned i = 0; i < 75; i++) begin
      push_tick(($urandom_range(19) == 0) ? pick_osc() : cur_osc,
                (i < 50) ? 1'($urandom_range(1)) : 1'b0, $urandom_range(19) == 0);
      n++;
    end
    return n;
  endfunction

  // Sense high too short or too long
  function automatic int unsigned add_broken();
    int unsigned len;
    int unsigned lows;
    len  = $urandom_range(1) ? $urandom_range(1, SenseMin-1) : $urandom_range(SenseMax+1, 140);
    lows = $urandom_range(1, 5);
    push_tick(cur_osc, 1'b0, 1'b0);
    for (int unsigned i = 0; i < len; i++) push_tick(cur_osc, 1'b1, 1'b0);
    for (int unsigned i = 0; i < lows; i++) push_tick(pick_osc(), 1'b0, $urandom_range(9) == 0);
    return len + lows + 1;
  endfunction

  function automatic int unsigned add_noise();
    int unsigned m;
    m = $urandom_range(5, 20);
    for (int unsigned i = 0; i < m; i++)
      push_tick(($urandom_range(2) == 0) ? pick_osc() : cur_osc, 1'($urandom_range(1)),
                $urandom_range(9) == 0);
    return m;
  endfunction

  function automatic void add_random(input int unsigned count);
    int unsigned added;
    int unsigned sel;
    added = 0;
    while (added < count) begin
      sel = $urandom_range(99);
      if (sel < 55) added += add_handshake($urandom_range(SenseMin, SenseMax));
      else if (sel < 75) added += add_broken();
      else added += add_noise();
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (ticks_to_send.size() != 0 || s_axis_tvalid || lines_due.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [TicksW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_TUNE_TICKS) tune_len = val;
    else band_len = val;
  endtask

  initial begin
    reset_tuner();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Word extremes, exact and just-above band edges, tune with band change
    push_tick('0, 1'b0, 1'b0);
    push_tick('1, 1'b0, 1'b0);
    push_tick('1, 1'b1, 1'b1);
    push_tick('1, 1'b0, 1'b0);
    for (int k = 0; k < NumEdges; k++)
      push_tick(BAND_EDGE[k] + (k % 2), 1'b0, k == 5);
    push_tick('0, 1'b0, 1'b1);
    push_tick(32'h0000_0001, 1'b0, 1'b0);
    wait_drained();

    // Longest tune pulse, shortest band pulse; sender idles lightly
    write_reg(CFG_TUNE_TICKS, '1);
    write_reg(CFG_BAND_TICKS, 16'd1);
    @(negedge clk_i);
    snd_idle_pct = 30;
    rcv_idle_pct = 87;
    add_random(70);
    wait_drained();

    // Swap extremes and idling
    write_reg(CFG_TUNE_TICKS, 16'd1);
    write_reg(CFG_BAND_TICKS, '1);
    @(negedge clk_i);
    snd_idle_pct = 87;
    rcv_idle_pct = 30;
    add_random(70);
    wait_drained();

    // Short pulses at full rate; hold the result side to back up the input
    write_reg(CFG_TUNE_TICKS, 16'($urandom_range(2, 40)));
    write_reg(CFG_BAND_TICKS, 16'($urandom_range(2, 40)));
    @(negedge clk_i);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    stall_requests++;
    add_random(20);
    wait_drained();
    // Sense high long enough to wrap the high-time counter into range
    void'(add_handshake(256 + $urandom_range(SenseMin, SenseMax)));
    add_random(20);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
